>>> hdl/spl_pkg.sv
// ----------------------------------------------------------------------------
// Sorted priority list package
// Shared types, sizes and codes for the sorted priority list block.
// ----------------------------------------------------------------------------
package spl_pkg;

   // Store size and derived widths.
   localparam int DEPTH    = 64;
   localparam int IDX_BITS = $clog2(DEPTH);
   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam int TAG_BITS = 16;

   // Operation codes.
   typedef enum logic [2:0] {
      OP_INSERT     = 3'd0,
      OP_REMOVE_TAG = 3'd1,
      OP_REMOVE_PRI = 3'd2,
      OP_CLEAR      = 3'd3,
      OP_READ       = 3'd4
   } op_type;

   // Status codes.
   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_EMPTY     = 3'd1,
      ST_NOT_FOUND = 3'd2,
      ST_FULL      = 3'd3,
      ST_BAD_POS   = 3'd4
   } status_type;

   // Request word.
   typedef struct packed {
      logic [2:0]          op;
      logic [TAG_BITS-1:0] tag;
      logic signed [15:0]  priority_req;
      logic [5:0]          position;
   } req_type;

   // Response word.
   typedef struct packed {
      logic [2:0]          status;
      logic [TAG_BITS-1:0] out_tag;
      logic signed [15:0]  out_priority;
      logic [6:0]          entry_count;
   } rsp_type;

   // One stored entry.
   typedef struct packed {
      logic [TAG_BITS-1:0] tag;
      logic signed [15:0]  prio;
   } entry_type;

endpackage

>>> hdl/sorted_priority_list.sv
// Clear, full insert, empty remove or read, bad position and unused codes respond
// straight from idle; read checks one entry; remove scans every entry from the head;
// insert scans from the tail, moving larger entries one slot back, and ends in the put
// state when it lands at the head. One word at a time: busy stays high until the response
// strobe. The entry memory has one registered read and one write per cycle. Synchronous
// reset empties the list; the receiver cannot stall, so each response shows for one cycle.
// ----------------------------------------------------------------------------
// Sorted priority list
// Keeps tagged entries in ascending priority order in one memory, scanned
// one entry at a time, load then check, by a small sequencer.
// ----------------------------------------------------------------------------
module sorted_priority_list
   import spl_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  req_type req_data,
   output logic    busy,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_LOAD,
      S_CHECK,
      S_PUT
   } state_type;

   state_type           state_ff;
   req_type             req_ff;
   logic [IDX_BITS-1:0] idx_ff;
   logic [IDX_BITS-1:0] put_ff;
   logic [CNT_BITS-1:0] count_ff;
   logic                found_ff;
   entry_type           hit_ff;
   logic                rsp_valid_ff;
   rsp_type             rsp_ff;

   entry_type           mem [DEPTH];
   entry_type           rd_data_ff;

   logic                mem_we;
   logic [IDX_BITS-1:0] mem_waddr;
   entry_type           mem_wdata;

   entry_type           new_entry;
   logic                is_last;
   logic                match;
   logic [IDX_BITS-1:0] last_idx;

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign new_entry.tag  = req_ff.tag;
   assign new_entry.prio = req_ff.priority_req;
   assign last_idx       = IDX_BITS'(count_ff - CNT_BITS'(1));
   assign is_last        = (idx_ff == last_idx);
   assign match          = (op_type'(req_ff.op) == OP_REMOVE_TAG) ?
                           (rd_data_ff.tag == req_ff.tag) :
                           (rd_data_ff.prio == req_ff.priority_req);

   // Entry memory: one registered read, one write per cycle.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[idx_ff];
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
   end

   // Memory write selection for the scan steps.
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = idx_ff;
      mem_wdata = new_entry;
      if (state_ff == S_PUT) begin
         mem_we    = 1'b1;
         mem_waddr = put_ff;
      end else if (state_ff == S_CHECK) begin
         if (op_type'(req_ff.op) == OP_INSERT) begin
            // Shift larger entries one slot toward the tail, else drop in.
            mem_we    = 1'b1;
            mem_waddr = idx_ff + IDX_BITS'(1);
            if (rd_data_ff.prio > req_ff.priority_req) begin
               mem_wdata = rd_data_ff;
            end
         end else if (op_type'(req_ff.op) != OP_READ && found_ff) begin
            // Close the gap left by the removed entry.
            mem_we    = 1'b1;
            mem_waddr = idx_ff - IDX_BITS'(1);
            mem_wdata = rd_data_ff;
         end
      end
   end

   // Sequencer with registered response.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
         idx_ff       <= '0;
         put_ff       <= '0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  req_ff               <= req_data;
                  found_ff             <= 1'b0;
                  rsp_ff.out_tag       <= '0;
                  rsp_ff.out_priority  <= '0;
                  rsp_ff.status        <= ST_OK;
                  rsp_ff.entry_count   <= 7'(count_ff);
                  case (op_type'(req_data.op))
                     OP_INSERT: begin
                        if (count_ff == CNT_BITS'(DEPTH)) begin
                           rsp_ff.status <= ST_FULL;
                           rsp_valid_ff  <= 1'b1;
                        end else if (count_ff == '0) begin
                           put_ff   <= '0;
                           state_ff <= S_PUT;
                        end else begin
                           idx_ff   <= last_idx;
                           state_ff <= S_LOAD;
                        end
                     end
                     OP_REMOVE_TAG, OP_REMOVE_PRI: begin
                        if (count_ff == '0) begin
                           rsp_ff.status <= ST_EMPTY;
                           rsp_valid_ff  <= 1'b1;
                        end else begin
                           idx_ff   <= '0;
                           state_ff <= S_LOAD;
                        end
                     end
                     OP_CLEAR: begin
                        count_ff           <= '0;
                        rsp_ff.entry_count <= '0;
                        rsp_valid_ff       <= 1'b1;
                     end
                     OP_READ: begin
                        if (count_ff == '0) begin
                           rsp_ff.status <= ST_EMPTY;
                           rsp_valid_ff  <= 1'b1;
                        end else if (CNT_BITS'(req_data.position) >= count_ff) begin
                           rsp_ff.status <= ST_BAD_POS;
                           rsp_valid_ff  <= 1'b1;
                        end else begin
                           idx_ff   <= IDX_BITS'(req_data.position);
                           state_ff <= S_LOAD;
                        end
                     end
                     default: begin
                        rsp_valid_ff <= 1'b1;
                     end
                  endcase
               end
            end

            // Read data for idx_ff arrives at the end of this cycle.
            S_LOAD: begin
               state_ff <= S_CHECK;
            end

            S_CHECK: begin
               case (op_type'(req_ff.op))
                  OP_INSERT: begin
                     if (rd_data_ff.prio > req_ff.priority_req) begin
                        if (idx_ff == '0) begin
                           put_ff   <= '0;
                           state_ff <= S_PUT;
                        end else begin
                           idx_ff   <= idx_ff - IDX_BITS'(1);
                           state_ff <= S_LOAD;
                        end
                     end else begin
                        count_ff           <= count_ff + CNT_BITS'(1);
                        rsp_ff.entry_count <= 7'(count_ff + CNT_BITS'(1));
                        rsp_valid_ff       <= 1'b1;
                        state_ff           <= S_IDLE;
                     end
                  end
                  OP_READ: begin
                     rsp_ff.out_tag      <= rd_data_ff.tag;
                     rsp_ff.out_priority <= rd_data_ff.prio;
                     rsp_valid_ff        <= 1'b1;
                     state_ff            <= S_IDLE;
                  end
                  default: begin
                     // Remove by tag or by priority: first match from the head.
                     if (!found_ff && match) begin
                        found_ff <= 1'b1;
                        hit_ff   <= rd_data_ff;
                     end
                     if (is_last) begin
                        if (found_ff || match) begin
                           count_ff            <= count_ff - CNT_BITS'(1);
                           rsp_ff.entry_count  <= 7'(count_ff - CNT_BITS'(1));
                           rsp_ff.out_tag      <= found_ff ? hit_ff.tag : rd_data_ff.tag;
                           rsp_ff.out_priority <= found_ff ? hit_ff.prio :
                                                             rd_data_ff.prio;
                        end else begin
                           rsp_ff.status <= ST_NOT_FOUND;
                        end
                        rsp_valid_ff <= 1'b1;
                        state_ff     <= S_IDLE;
                     end else begin
                        idx_ff   <= idx_ff + IDX_BITS'(1);
                        state_ff <= S_LOAD;
                     end
                  end
               endcase
            end

            // Write the new entry at its slot and finish the insert.
            S_PUT: begin
               count_ff           <= count_ff + CNT_BITS'(1);
               rsp_ff.entry_count <= 7'(count_ff + CNT_BITS'(1));
               rsp_valid_ff       <= 1'b1;
               state_ff           <= S_IDLE;
            end

            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule
